[rtl/obpt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpt_pkg: shared types, constants and functions of the oriented box test
// Register map, configuration record, fixed-point rounding and saturation
// helpers, and the quarter-wave sine generator that fills the sine ROM.
// ----------------------------------------------------------------------------
package obpt_pkg;

  // Default fixed-point format and sine table size
  localparam int FRACTION_BITS_DEF      = 16;
  localparam int SINE_ADDRESS_BITS_DEF  = 10;

  // Pipeline depth, stage 1 takes the input transfer, the last stage is the output
  localparam int STAGES = 9;

  // Angle reduction: 360 degrees = 8 * 45, rounding adds half a turn
  localparam int ANGLE_DIV     = 45;
  localparam int HALF_TURN_DEG = 180;

  // Sine generator constants (Q2.30)
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Scale registers reset to 1.0 in Q16.16
  localparam logic signed [31:0] SCALE_RESET = 32'sh0001_0000;

  // Register indexes
  typedef enum logic [2:0] {
    REG_BOX_WIDTH         = 3'd0,
    REG_BOX_HEIGHT        = 3'd1,
    REG_BOX_OFFSET_X      = 3'd2,
    REG_BOX_OFFSET_Y      = 3'd3,
    REG_SCALE_HORIZONTAL  = 3'd4,
    REG_SCALE_VERTICAL    = 3'd5,
    REG_TRANSFORM_PRESENT = 3'd6
  } reg_index_t;

  // Configuration record
  typedef struct packed {
    logic signed [31:0] box_width;
    logic signed [31:0] box_height;
    logic signed [31:0] box_offset_x;
    logic signed [31:0] box_offset_y;
    logic signed [31:0] scale_horizontal;
    logic signed [31:0] scale_vertical;
    logic               transform_present;
  } cfg_t;

  // Round to nearest, ties toward plus infinity, dropping fb fraction bits
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                     input int fb);
    logic signed [63:0] biased;
    biased = p + (64'sd1 <<< (fb - 1));
    return biased >>> fb;
  endfunction

  // Absolute value saturated to 0x7FFFFFFF
  function automatic logic [30:0] abs_sat31(input logic signed [63:0] v);
    logic signed [63:0] mag;
    mag = (v < 0) ? -v : v;
    return (mag > 64'sd2147483647) ? 31'h7FFF_FFFF : mag[30:0];
  endfunction

  // Saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // First-quadrant sine of j table steps, thirteen-term Taylor series in Q2.30,
  // result rounded to fb fraction bits. Elaboration only. Term k is divided
  // by (2k)(2k+1): 6, 20, 42, ... 600; odd terms subtract.
  function automatic longint unsigned quarter_sine(input longint unsigned j,
                                                   input int fb, input int ab);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x    = (j * (2 * PI_Q30) + (64'd1 << (ab - 1))) >> ab;
    x2   = (x * x) >> 30;
    term = x;
    s    = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  s = s + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  s = s + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; s = s + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; s = s + $signed(term);
    term = ((term * x2) >> 30) / 64'd342; s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd420; s = s + $signed(term);
    term = ((term * x2) >> 30) / 64'd506; s = s - $signed(term);
    term = ((term * x2) >> 30) / 64'd600; s = s + $signed(term);
    if (s < 0) begin
      s = 0;
    end
    return $unsigned(s + (64'sd1 <<< (29 - fb))) >> (30 - fb);
  endfunction

endpackage
`default_nettype wire

[rtl/obpt_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpt_scale: scaled box geometry
// Stage 1 multiplies size and offset by the scale registers, stage 2 rounds,
// takes the absolute size and saturates.
// ----------------------------------------------------------------------------
module obpt_scale #(
  parameter int FRACTION_BITS = obpt_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic [obpt_pkg::STAGES:1]     en,
  input  obpt_pkg::cfg_t                cfg,
  output logic [30:0]                   size_w,
  output logic [30:0]                   size_h,
  output logic signed [31:0]            off_x,
  output logic signed [31:0]            off_y
);

  logic signed [63:0] prod_w;
  logic signed [63:0] prod_h;
  logic signed [63:0] prod_ox;
  logic signed [63:0] prod_oy;

  // Stage 1: raw products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod_w  <= cfg.box_width    * cfg.scale_horizontal;
      prod_h  <= cfg.box_height   * cfg.scale_vertical;
      prod_ox <= cfg.box_offset_x * cfg.scale_horizontal;
      prod_oy <= cfg.box_offset_y * cfg.scale_vertical;
    end
  end

  // Stage 2: round, abs/saturate
  always_ff @(posedge clk) begin
    if (en[2]) begin
      size_w <= obpt_pkg::abs_sat31(obpt_pkg::round_shift(prod_w, FRACTION_BITS));
      size_h <= obpt_pkg::abs_sat31(obpt_pkg::round_shift(prod_h, FRACTION_BITS));
      off_x  <= obpt_pkg::sat32(obpt_pkg::round_shift(prod_ox, FRACTION_BITS));
      off_y  <= obpt_pkg::sat32(obpt_pkg::round_shift(prod_oy, FRACTION_BITS));
    end
  end

endmodule
`default_nettype wire

[rtl/obpt_angle.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpt_angle: rotation angle to sine table index
// Negates the angle, reduces it modulo 360 degrees and rounds it to table
// steps. Both divisions by 45 use a reciprocal multiply; stages 1 to 4.
// ----------------------------------------------------------------------------
module obpt_angle #(
  parameter int FRACTION_BITS     = obpt_pkg::FRACTION_BITS_DEF,
  parameter int SINE_ADDRESS_BITS = obpt_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  logic                              clk,
  input  logic [obpt_pkg::STAGES:1]         en,
  input  logic signed [31:0]                rotation_degrees,
  output logic [SINE_ADDRESS_BITS-1:0]      idx
);

  localparam int F  = FRACTION_BITS;
  localparam int A  = SINE_ADDRESS_BITS;
  // whole degrees / 8, biased non-negative
  localparam int TW   = 31 - F;
  localparam int BIAS = obpt_pkg::ANGLE_DIV * (2 ** (24 - F));
  localparam int S1   = TW + 6;
  localparam int M1W  = TW + 1;
  localparam longint unsigned M1 =
    ((64'd1 << S1) + 64'(obpt_pkg::ANGLE_DIV - 1)) / 64'(obpt_pkg::ANGLE_DIV);
  // rounded step count / 8
  localparam int UW   = A + 7;
  localparam int S2   = UW + 6;
  localparam int M2W  = UW + 1;
  localparam longint unsigned M2 =
    ((64'd1 << S2) + 64'(obpt_pkg::ANGLE_DIV - 1)) / 64'(obpt_pkg::ANGLE_DIV);

  logic signed [32:0] neg_rot;
  logic [TW-1:0]      t_next;
  logic [TW-1:0]      t1;
  logic [2:0]         low1;
  logic [F-1:0]       frac1;
  logic [TW+M1W-1:0]  prod2;
  logic [TW-1:0]      t2;
  logic [2:0]         low2;
  logic [F-1:0]       frac2;
  logic [TW-1:0]      q45;
  logic [TW-1:0]      rem_full;
  logic [8:0]         deg;
  logic [8+F+A:0]     r_steps;
  logic [A+9:0]       p_next;
  logic [A+9:0]       p3;
  logic [UW+M2W-1:0]  prod4;

  // Stage 1: negate, split into whole degrees and fraction
  assign neg_rot = -{rotation_degrees[31], rotation_degrees};
  assign t_next  = TW'(neg_rot >>> (F + 3)) + TW'(BIAS);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1    <= t_next;
      low1  <= neg_rot[F+2:F];
      frac1 <= neg_rot[F-1:0];
    end
  end

  // Stage 2: reciprocal multiply for the quotient by 45
  always_ff @(posedge clk) begin
    if (en[2]) begin
      prod2 <= t1 * M1W'(M1);
      t2    <= t1;
      low2  <= low1;
      frac2 <= frac1;
    end
  end

  // Stage 3: remainder gives degrees in [0, 360), scale to steps, add half turn
  always_comb begin
    q45      = TW'(prod2 >> S1);
    rem_full = t2 - TW'(q45 * TW'(obpt_pkg::ANGLE_DIV));
    deg      = {rem_full[5:0], low2};
    r_steps  = {deg, frac2, {A{1'b0}}};
    p_next   = {1'b0, r_steps[8+F+A:F]} + (A+10)'(obpt_pkg::HALF_TURN_DEG);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      p3 <= p_next;
    end
  end

  // Stage 4: divide by 360 as shift by 3 and reciprocal multiply by 45
  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod4 <= p3[A+9:3] * M2W'(M2);
    end
  end

  // quotient wraps to the table size
  assign idx = A'(prod4 >> S2);

endmodule
`default_nettype wire

[rtl/obpt_sincos.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// obpt_sincos: sine and cosine lookup
// Folds the table index into the first quadrant (stage 5) and reads a
// quarter-wave ROM at two addresses with registered data (stage 6).
// ----------------------------------------------------------------------------
module obpt_sincos #(
  parameter int FRACTION_BITS     = obpt_pkg::FRACTION_BITS_DEF,
  parameter int SINE_ADDRESS_BITS = obpt_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  logic                          clk,
  input  logic [obpt_pkg::STAGES:1]     en,
  input  logic [SINE_ADDRESS_BITS-1:0]  idx,
  output logic [FRACTION_BITS:0]        sin_mag,
  output logic [FRACTION_BITS:0]        cos_mag,
  output logic                          sin_neg,
  output logic                          cos_neg
);

  localparam int F       = FRACTION_BITS;
  localparam int A       = SINE_ADDRESS_BITS;
  localparam int QUARTER = 2 ** (A - 2);
  localparam int JW      = A - 1;

  logic [F:0]    rom [QUARTER+1];
  logic [A-1:0]  cidx;
  logic [JW-1:0] js_next;
  logic [JW-1:0] jc_next;
  logic [JW-1:0] js;
  logic [JW-1:0] jc;
  logic          ns5;
  logic          nc5;

  // Quarter-wave table, one entry per step including the peak
  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign rom[g] = (F+1)'(obpt_pkg::quarter_sine(64'(g), F, A));
  end

  // Stage 5: quadrant fold; cosine is a quarter turn ahead
  assign cidx    = idx + A'(QUARTER);
  assign js_next = idx[A-2]  ? JW'(QUARTER) - {1'b0, idx[A-3:0]}  : {1'b0, idx[A-3:0]};
  assign jc_next = cidx[A-2] ? JW'(QUARTER) - {1'b0, cidx[A-3:0]} : {1'b0, cidx[A-3:0]};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      js  <= js_next;
      jc  <= jc_next;
      ns5 <= idx[A-1];
      nc5 <= cidx[A-1];
    end
  end

  // Stage 6: registered ROM read
  always_ff @(posedge clk) begin
    if (en[6]) begin
      sin_mag <= rom[js];
      cos_mag <= rom[jc];
      sin_neg <= ns5;
      cos_neg <= nc5;
    end
  end

endmodule
`default_nettype wire

[rtl/oriented_box_point_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_box_point_test: point in rotated, scaled box test
// Nine-stage pipeline: scale, angle reduction, sine lookup, rotation, compare.
// ----------------------------------------------------------------------------
// Takes one query per clock while the output side is not stalled and returns
// one inside/outside flag per query. Every stage holds at most one
// multiplier per product (the scale products, the two reciprocal multiplies
// of the angle reduction and the four rotation products), so a new item
// enters every cycle; a stall at the output fills empty stages first and
// then holds the input side. Configuration registers are write-only and
// must be changed only while no item is in flight; the sine ROM is a
// constant table and needs no initialization after reset.
module oriented_box_point_test #(
  parameter int FRACTION_BITS     = obpt_pkg::FRACTION_BITS_DEF,
  parameter int SINE_ADDRESS_BITS = obpt_pkg::SINE_ADDRESS_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // query stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // query_x[31:0], query_y[63:32], position_horizontal[95:64],
  // position_vertical[127:96], rotation_degrees[159:128]
  input  logic [159:0] s_tdata,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res[0], zero fill [7:1]
  output logic [7:0]   m_tdata,
  // configuration writes
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  localparam int NS  = obpt_pkg::STAGES;
  localparam int F   = FRACTION_BITS;
  localparam int LXW = 34;
  localparam int PW  = LXW + F + 2;
  localparam int RW  = PW + 1;

  obpt_pkg::cfg_t cfg;

  logic [NS:1] vld;
  logic [NS:1] en;

  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic signed [31:0] position_horizontal;
  logic signed [31:0] position_vertical;
  logic signed [31:0] rotation_degrees;

  logic signed [31:0] qx1, qy1, px1, py1;
  logic signed [31:0] qx2, qy2, px2, py2;

  logic [30:0]        size_w;
  logic [30:0]        size_h;
  logic signed [31:0] off_x;
  logic signed [31:0] off_y;

  logic [30:0]           sw_d [3:8];
  logic [30:0]           sh_d [3:8];
  logic signed [LXW-1:0] lx_d [3:6];
  logic signed [LXW-1:0] ly_d [3:6];

  logic [SINE_ADDRESS_BITS-1:0] idx;
  logic [F:0]                   sin_mag;
  logic [F:0]                   cos_mag;
  logic                         sin_neg;
  logic                         cos_neg;

  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic                 ns7, nc7;
  logic signed [RW-1:0] t_xc, t_ys, t_xs, t_yc;
  logic signed [RW-1:0] rx, ry;
  logic signed [RW-1:0] half_w, half_h;
  logic                 inside_next;
  logic                 inside_res;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_width         <= '0;
      cfg.box_height        <= '0;
      cfg.box_offset_x      <= '0;
      cfg.box_offset_y      <= '0;
      cfg.scale_horizontal  <= obpt_pkg::SCALE_RESET;
      cfg.scale_vertical    <= obpt_pkg::SCALE_RESET;
      cfg.transform_present <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (obpt_pkg::reg_index_t'(cfg_index))
        obpt_pkg::REG_BOX_WIDTH:         cfg.box_width         <= cfg_wdata;
        obpt_pkg::REG_BOX_HEIGHT:        cfg.box_height        <= cfg_wdata;
        obpt_pkg::REG_BOX_OFFSET_X:      cfg.box_offset_x      <= cfg_wdata;
        obpt_pkg::REG_BOX_OFFSET_Y:      cfg.box_offset_y      <= cfg_wdata;
        obpt_pkg::REG_SCALE_HORIZONTAL:  cfg.scale_horizontal  <= cfg_wdata;
        obpt_pkg::REG_SCALE_VERTICAL:    cfg.scale_vertical    <= cfg_wdata;
        obpt_pkg::REG_TRANSFORM_PRESENT: cfg.transform_present <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NS] = !vld[NS] || m_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NS];
  assign m_tdata  = {7'd0, inside_res};

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input fields
  assign query_x             = s_tdata[31:0];
  assign query_y             = s_tdata[63:32];
  assign position_horizontal = s_tdata[95:64];
  assign position_vertical   = s_tdata[127:96];
  assign rotation_degrees    = s_tdata[159:128];

  obpt_scale #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scale (
    .clk    (clk),
    .en     (en),
    .cfg    (cfg),
    .size_w (size_w),
    .size_h (size_h),
    .off_x  (off_x),
    .off_y  (off_y)
  );

  obpt_angle #(
    .FRACTION_BITS     (FRACTION_BITS),
    .SINE_ADDRESS_BITS (SINE_ADDRESS_BITS)
  ) u_angle (
    .clk              (clk),
    .en               (en),
    .rotation_degrees (rotation_degrees),
    .idx              (idx)
  );

  obpt_sincos #(
    .FRACTION_BITS     (FRACTION_BITS),
    .SINE_ADDRESS_BITS (SINE_ADDRESS_BITS)
  ) u_sincos (
    .clk     (clk),
    .en      (en),
    .idx     (idx),
    .sin_mag (sin_mag),
    .cos_mag (cos_mag),
    .sin_neg (sin_neg),
    .cos_neg (cos_neg)
  );

  // Stages 1-2: point and position ride along with the scale products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      qx1 <= query_x;
      qy1 <= query_y;
      px1 <= position_horizontal;
      py1 <= position_vertical;
    end
    if (en[2]) begin
      qx2 <= qx1;
      qy2 <= qy1;
      px2 <= px1;
      py2 <= py1;
    end
  end

  // Stage 3: offset from the box center; sizes delayed to the compare
  always_ff @(posedge clk) begin
    if (en[3]) begin
      lx_d[3] <= {{2{qx2[31]}}, qx2} - {{2{px2[31]}}, px2} - {{2{off_x[31]}}, off_x};
      ly_d[3] <= {{2{qy2[31]}}, qy2} - {{2{py2[31]}}, py2} - {{2{off_y[31]}}, off_y};
      sw_d[3] <= size_w;
      sh_d[3] <= size_h;
    end
    for (int k = 4; k <= 6; k++) begin
      if (en[k]) begin
        lx_d[k] <= lx_d[k-1];
        ly_d[k] <= ly_d[k-1];
      end
    end
    for (int k = 4; k <= 8; k++) begin
      if (en[k]) begin
        sw_d[k] <= sw_d[k-1];
        sh_d[k] <= sh_d[k-1];
      end
    end
  end

  // Stage 7: rotation products with table magnitudes
  always_ff @(posedge clk) begin
    if (en[7]) begin
      p_xc <= lx_d[6] * $signed({1'b0, cos_mag});
      p_ys <= ly_d[6] * $signed({1'b0, sin_mag});
      p_xs <= lx_d[6] * $signed({1'b0, sin_mag});
      p_yc <= ly_d[6] * $signed({1'b0, cos_mag});
      ns7  <= sin_neg;
      nc7  <= cos_neg;
    end
  end

  // Stage 8: apply quadrant signs, rotate by minus the angle
  always_comb begin
    t_xc = nc7 ? -RW'(p_xc) : RW'(p_xc);
    t_ys = ns7 ? -RW'(p_ys) : RW'(p_ys);
    t_xs = ns7 ? -RW'(p_xs) : RW'(p_xs);
    t_yc = nc7 ? -RW'(p_yc) : RW'(p_yc);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      rx <= t_xc - t_ys;
      ry <= t_xs + t_yc;
    end
  end

  // Stage 9: compare against half sizes at full precision, edges inside
  assign half_w = $signed(RW'({sw_d[8], {(F-1){1'b0}}}));
  assign half_h = $signed(RW'({sh_d[8], {(F-1){1'b0}}}));
  assign inside_next = cfg.transform_present &&
                       (rx >= -half_w) && (rx <= half_w) &&
                       (ry >= -half_h) && (ry <= half_h);

  always_ff @(posedge clk) begin
    if (en[9]) begin
      inside_res <= inside_next;
    end
  end

  // An output register that is empty or draining opens the whole pipe
  a_ready_open: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input blocked while the output side can move");

  // An input transfer lands in stage 1
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted item missing from stage 1");

  // A blocked stage 1 keeps its item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[1] && !en[1]) |=> vld[1])
    else $error("stalled item dropped from stage 1");

endmodule
`default_nettype wire
